FILE: design/multi_axis_pid_controller_defines.svh
// Assertion macros for the multi-axis PID controller.
// Included by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef MULTI_AXIS_PID_CONTROLLER_DEFINES_SVH
`define MULTI_AXIS_PID_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define MAPID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MAPID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mapid_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register codes and the per-axis state entry type.
// No dependencies.
package mapid_pkg;

  localparam int AXIS_W    = 2;
  localparam int POS_W     = 16;
  localparam int ERR_W     = 17;
  localparam int DIFF_W    = 18;
  localparam int INTEG_W   = 32;
  localparam int GAIN_W    = 20;
  localparam int DRV_W     = 12;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;
  localparam int PP_W      = GAIN_W + 1 + ERR_W;
  localparam int PI_W      = GAIN_W + 1 + INTEG_W;
  localparam int PD_W      = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W     = PI_W + 2;
  localparam int CORR_W    = ACC_W - FRAC_W;

  localparam logic [GAIN_W-1:0] KP_RESET   = GAIN_W'(76800);
  localparam logic [GAIN_W-1:0] KI_RESET   = GAIN_W'(154);
  localparam logic [GAIN_W-1:0] KD_RESET   = GAIN_W'(256);
  localparam logic [DRV_W-1:0]  MAX_RESET  = DRV_W'(2000);
  localparam logic [DRV_W-1:0]  MIN_RESET  = DRV_W'(1000);
  localparam logic [DRV_W-1:0]  BASE_RESET = DRV_W'(1500);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_GAIN  = 3'd0,
    REG_KI_GAIN  = 3'd1,
    REG_KD_GAIN  = 3'd2,
    REG_OUT_MAX  = 3'd3,
    REG_OUT_MIN  = 3'd4,
    REG_OUT_BASE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [INTEG_W-1:0] integ;
    logic signed [ERR_W-1:0]   err;
    logic [DRV_W-1:0]          drive;
  } state_entry_t;

endpackage

FILE: design/mapid_state_ram.sv
`timescale 1ns / 1ps
// Per-axis state memory: one entry per axis, registered read, valid bits.
// Depends on mapid_pkg.
module mapid_state_ram #(
  parameter int AXES = 3,
  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_idx,
  output mapid_pkg::state_entry_t rd_data,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_idx,
  input  mapid_pkg::state_entry_t wr_data
);
  import mapid_pkg::*;

  state_entry_t    mem [AXES];
  state_entry_t    rd_q;
  logic            rd_vld;
  logic [AXES-1:0] vld;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld <= vld[rd_idx];
      end
      if (wr_en) begin
        vld[wr_idx] <= 1'b1;
      end
    end
  end

  // never-written entry reads as the reset state
  assign rd_data = rd_vld ? rd_q : '0;

endmodule

FILE: design/multi_axis_pid_controller.sv
`timescale 1ns / 1ps
// Multi-axis PID controller top level: config registers, five-stage datapath,
// output register. Depends on mapid_pkg, mapid_state_ram and the defines header.
//
//   channel   dir  handshake               contents
//   s_axis    in   tvalid/tready           tdata: target, measured; tuser: axis
//   m_axis    out  tvalid/tready           tdata: drive; tuser: axis_out, at_limit
//   cfg       in   cfg_we (no wait)        cfg_index, cfg_data
//
// A result reaches m_axis through six register stages (A to E and the output register).
// Items for different axes enter every cycle while m_axis is not stalled; an item for an
// axis still in the five datapath stages waits until that axis's state is written back, so
// an axis takes no new item before its last leaves stage E (state memory read-modify-write loop).
// Reset clears config to defaults and all axis state to zero at once.
// A stalled m_axis fills the stages behind it before s_axis_tready drops.
module multi_axis_pid_controller #(
  parameter int AXES = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] target, [31:16] measured
  input  logic [1:0]  s_axis_tuser,   // [1:0] axis
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] drive, zero fill above
  output logic [2:0]  m_axis_tuser,   // [1:0] axis_out, [2] at_limit
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import mapid_pkg::*;
  `include "multi_axis_pid_controller_defines.svh"

  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

  // configuration
  logic [GAIN_W-1:0] kp_gain, ki_gain, kd_gain;
  logic [DRV_W-1:0]  out_max, out_min, out_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain  <= KP_RESET;
      ki_gain  <= KI_RESET;
      kd_gain  <= KD_RESET;
      out_max  <= MAX_RESET;
      out_min  <= MIN_RESET;
      out_base <= BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP_GAIN:  kp_gain  <= cfg_data[GAIN_W-1:0];
        REG_KI_GAIN:  ki_gain  <= cfg_data[GAIN_W-1:0];
        REG_KD_GAIN:  kd_gain  <= cfg_data[GAIN_W-1:0];
        REG_OUT_MAX:  out_max  <= cfg_data[DRV_W-1:0];
        REG_OUT_MIN:  out_min  <= cfg_data[DRV_W-1:0];
        REG_OUT_BASE: out_base <= cfg_data[DRV_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and flow control
  logic a_valid, b_valid, c_valid, d_valid, e_valid, o_valid;
  logic a_ready, b_ready, c_ready, d_ready, e_ready, o_ready;
  logic [AXIS_W-1:0] a_axis, b_axis, c_axis, d_axis, e_axis, o_axis;

  assign o_ready = !o_valid || m_axis_tready;
  assign e_ready = !e_valid || o_ready;
  assign d_ready = !d_valid || e_ready;
  assign c_ready = !c_valid || d_ready;
  assign b_ready = !b_valid || c_ready;
  assign a_ready = !a_valid || b_ready;

  // input
  logic [AXIS_W-1:0]      in_axis;
  logic signed [POS_W-1:0] in_tgt, in_meas;
  logic signed [ERR_W-1:0] in_err;
  logic in_range, conflict, accept;

  assign in_axis  = s_axis_tuser;
  assign in_tgt   = s_axis_tdata[15:0];
  assign in_meas  = s_axis_tdata[31:16];
  assign in_err   = in_tgt - in_meas;
  assign in_range = 32'(in_axis) < AXES;

  // axis state not yet written back
  assign conflict = (a_valid && a_axis == in_axis) || (b_valid && b_axis == in_axis)
                 || (c_valid && c_axis == in_axis) || (d_valid && d_axis == in_axis)
                 || (e_valid && e_axis == in_axis);

  assign s_axis_tready = a_ready && !conflict;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // state memory
  state_entry_t rd_data, wr_data;
  logic         wr_en;

  mapid_state_ram #(
    .AXES(AXES)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && in_range),
    .rd_idx  (AW'(in_axis)),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_idx  (AW'(e_axis)),
    .wr_data (wr_data)
  );

  // stage A: integrate and differentiate
  logic signed [ERR_W-1:0]   a_err;
  logic signed [INTEG_W:0]   a_sum;
  logic signed [INTEG_W-1:0] a_sat, a_integ;
  logic signed [DIFF_W-1:0]  a_diff;
  logic                      a_inside;

  always_comb begin
    a_sum = rd_data.integ + a_err;
    if (a_sum[INTEG_W] != a_sum[INTEG_W-1]) begin
      a_sat = a_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      a_sat = a_sum[INTEG_W-1:0];
    end
    a_inside = (rd_data.drive < out_max) && (rd_data.drive > out_min);
    a_integ  = a_inside ? a_sat : rd_data.integ;
    a_diff   = a_err - rd_data.err;
  end

  // stage B: gain products
  logic signed [INTEG_W-1:0] b_integ, c_integ, d_integ, e_integ;
  logic signed [ERR_W-1:0]   b_err, c_err, d_err, e_err;
  logic signed [DIFF_W-1:0]  b_diff;
  logic signed [PP_W-1:0]    b_pp, c_pp;
  logic signed [PI_W-1:0]    b_pi, c_pi;
  logic signed [PD_W-1:0]    b_pd, c_pd;

  assign b_pp = $signed({1'b0, kp_gain}) * b_err;
  assign b_pi = $signed({1'b0, ki_gain}) * b_integ;
  assign b_pd = $signed({1'b0, kd_gain}) * b_diff;

  // stage C: sum
  logic signed [ACC_W-1:0] c_acc, d_acc, d_bias;
  assign c_acc = c_pp + c_pi + c_pd;

  // stage D: truncate toward zero
  logic signed [CORR_W-1:0] d_corr, e_corr;
  assign d_bias = d_acc + ACC_W'({FRAC_W{d_acc[ACC_W-1]}});
  assign d_corr = d_bias[ACC_W-1:FRAC_W];

  // stage E: offset and clamp
  logic signed [CORR_W:0] e_val, e_lim;
  logic                   e_over, e_under;
  logic [DRV_W-1:0]       e_drive;

  always_comb begin
    e_val   = e_corr + $signed({1'b0, out_base});
    e_over  = e_val > $signed({1'b0, out_max});
    e_lim   = e_over ? (CORR_W + 1)'($signed({1'b0, out_max})) : e_val;
    e_under = e_lim < $signed({1'b0, out_min});
    e_drive = e_under ? out_min : e_lim[DRV_W-1:0];
  end

  assign wr_en   = e_valid && o_ready;
  assign wr_data = '{integ: e_integ, err: e_err, drive: e_drive};

  logic [DRV_W-1:0] o_drive;
  logic             o_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= accept && in_range;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
      if (d_ready) d_valid <= c_valid;
      if (e_ready) e_valid <= d_valid;
      if (o_ready) o_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_axis <= in_axis;
      a_err  <= in_err;
    end
    if (a_valid && b_ready) begin
      b_axis  <= a_axis;
      b_integ <= a_integ;
      b_err   <= a_err;
      b_diff  <= a_diff;
    end
    if (b_valid && c_ready) begin
      c_axis  <= b_axis;
      c_integ <= b_integ;
      c_err   <= b_err;
      c_pp    <= b_pp;
      c_pi    <= b_pi;
      c_pd    <= b_pd;
    end
    if (c_valid && d_ready) begin
      d_axis  <= c_axis;
      d_integ <= c_integ;
      d_err   <= c_err;
      d_acc   <= c_acc;
    end
    if (d_valid && e_ready) begin
      e_axis  <= d_axis;
      e_integ <= d_integ;
      e_err   <= d_err;
      e_corr  <= d_corr;
    end
    if (e_valid && o_ready) begin
      o_axis  <= e_axis;
      o_drive <= e_drive;
      o_limit <= e_over || e_under;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {{(16 - DRV_W){1'b0}}, o_drive};
  assign m_axis_tuser  = {o_limit, o_axis};

  `MAPID_ASSERT_IMP(a_ax_unique_b, a_valid && b_valid, a_axis != b_axis,
                    "two items of one axis in stages A and B")
  `MAPID_ASSERT_IMP(a_ax_unique_e, a_valid && e_valid, a_axis != e_axis,
                    "two items of one axis in stages A and E")
  `MAPID_ASSERT_NXT(bad_axis_drop, accept && !in_range && a_ready, !a_valid,
                    "out-of-range axis entered the datapath")
  `MAPID_ASSERT_IMP(unclamped_in_band, o_valid && !o_limit,
                    o_drive >= out_min && o_drive <= out_max,
                    "drive outside limits without limit flag")

endmodule

FILE: bench/pid_drive_checker.sv
`timescale 1ns / 1ps
// Checker for the multi-axis PID controller: watches s_axis, m_axis and cfg,
// predicts each drive transaction and compares it field by field. Uses mapid_pkg.
module pid_drive_checker #(
  parameter int AXES = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] target, [31:16] measured
  input  logic [1:0]  s_axis_tuser,   // [1:0] axis
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [11:0] drive, zero fill above
  input  logic [2:0]  m_axis_tuser,   // [1:0] axis_out, [2] at_limit
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output int          mismatch_count,
  output int          pending_count
);
  import mapid_pkg::*;

  localparam longint INTEG_HI = 64'sd2147483647;
  localparam longint INTEG_LO = -64'sd2147483648;

  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic [DRV_W-1:0]  drive;
    logic              at_limit;
  } drive_result_t;

  logic [GAIN_W-1:0] kp, ki, kd;
  logic [DRV_W-1:0]  out_max, out_min, out_base;
  int                integ_acc [AXES];
  int                err_hist [AXES];
  logic [DRV_W-1:0]  drive_hist [AXES];
  drive_result_t     pending_drives [$];

  initial mismatch_count = 0;
  initial pending_count = 0;

  task automatic report(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic drive_result_t next_drive(input logic [AXIS_W-1:0] axis,
                                               input logic signed [POS_W-1:0] target,
                                               input logic signed [POS_W-1:0] measured);
    longint err, integ, diff, acc, corr, val;
    drive_result_t r;
    r.at_limit = 1'b0;
    err = longint'(target) - longint'(measured);
    integ = integ_acc[axis];
    if (drive_hist[axis] < out_max && drive_hist[axis] > out_min) begin
      integ += err;
      if (integ > INTEG_HI) integ = INTEG_HI;
      if (integ < INTEG_LO) integ = INTEG_LO;
    end
    integ_acc[axis] = int'(integ);
    diff = err - longint'(err_hist[axis]);
    err_hist[axis] = int'(err);
    acc = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * diff;
    corr = acc / 65536;
    val = longint'(out_base) + corr;
    if (val > longint'(out_max)) begin
      val = longint'(out_max);
      r.at_limit = 1'b1;
    end
    if (val < longint'(out_min)) begin
      val = longint'(out_min);
      r.at_limit = 1'b1;
    end
    drive_hist[axis] = DRV_W'(val);
    r.axis = axis;
    r.drive = DRV_W'(val);
    return r;
  endfunction

  always @(posedge clk) begin
    drive_result_t want;
    if (rst) begin
      kp = KP_RESET;
      ki = KI_RESET;
      kd = KD_RESET;
      out_max = MAX_RESET;
      out_min = MIN_RESET;
      out_base = BASE_RESET;
      for (int a = 0; a < AXES; a++) begin
        integ_acc[a] = 0;
        err_hist[a] = 0;
        drive_hist[a] = '0;
      end
      pending_drives.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_KP_GAIN:  kp = cfg_data[GAIN_W-1:0];
          REG_KI_GAIN:  ki = cfg_data[GAIN_W-1:0];
          REG_KD_GAIN:  kd = cfg_data[GAIN_W-1:0];
          REG_OUT_MAX:  out_max = cfg_data[DRV_W-1:0];
          REG_OUT_MIN:  out_min = cfg_data[DRV_W-1:0];
          REG_OUT_BASE: out_base = cfg_data[DRV_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready && s_axis_tuser < AXES)
        pending_drives.push_back(next_drive(s_axis_tuser, s_axis_tdata[15:0],
                                            s_axis_tdata[31:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_drives.size() == 0) begin
          report($sformatf("drive transaction with none expected (axis %0d, drive %0d)",
                           m_axis_tuser[1:0], m_axis_tdata));
        end else begin
          want = pending_drives.pop_front();
          if (m_axis_tuser[1:0] !== want.axis)
            report($sformatf("axis_out %0d, expected %0d", m_axis_tuser[1:0], want.axis));
          if (m_axis_tdata !== 16'(want.drive))
            report($sformatf("axis %0d drive %0d, expected %0d",
                             want.axis, m_axis_tdata, want.drive));
          if (m_axis_tuser[2] !== want.at_limit)
            report($sformatf("axis %0d at_limit %0b, expected %0b",
                             want.axis, m_axis_tuser[2], want.at_limit));
        end
      end
    end
    pending_count <= pending_drives.size();
  end

endmodule

FILE: bench/multi_axis_pid_controller_test.sv
`timescale 1ns / 1ps
// Top of the PID controller bench: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Depends on mapid_pkg, the controller and pid_drive_checker.
module multi_axis_pid_controller_test;
  import mapid_pkg::*;

  localparam int AXES            = 3;
  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int FILL_ROUNDS     = 10;
  localparam logic [POS_W-1:0] POS_MAX = 16'h7FFF;
  localparam logic [POS_W-1:0] POS_MIN = 16'h8000;
  localparam logic [DRV_W-1:0] DRV_TOP = 12'hFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata = '0;   // [15:0] target, [31:16] measured
  logic [1:0]  s_axis_tuser = '0;   // [1:0] axis
  logic        m_axis_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [15:0] m_axis_tdata;        // [11:0] drive, zero fill above
  wire  [2:0]  m_axis_tuser;        // [1:0] axis_out, [2] at_limit

  int mismatch_count;
  int pending_count;
  int send_idle_pct = 34;
  int recv_idle_pct = 86;
  int holds_wanted = 0;
  int holds_done = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_axis_pid_controller #(.AXES(AXES)) uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pid_drive_checker #(.AXES(AXES)) drive_check (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .pending_count(pending_count)
  );

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done < holds_wanted) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic [AXIS_W-1:0] axis, input logic [POS_W-1:0] target,
                             input logic [POS_W-1:0] measured);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {measured, target};
    s_axis_tuser <= axis;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // also pokes an unused index; pad goes into the unused upper bits of the 12-bit regs
  task automatic program_regs(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd, input logic [DRV_W-1:0] hi,
                              input logic [DRV_W-1:0] lo, input logic [DRV_W-1:0] base,
                              input logic [7:0] pad);
    write_reg(CFG_IDX_W'(REG_OUT_BASE + 1 + $urandom_range(1)), CFG_W'($urandom));
    write_reg(REG_KP_GAIN, kp);
    write_reg(REG_KI_GAIN, ki);
    write_reg(REG_KD_GAIN, kd);
    write_reg(REG_OUT_MAX, {pad, hi});
    write_reg(REG_OUT_MIN, {pad, lo});
    write_reg(REG_OUT_BASE, {pad, base});
    cfg_we <= 1'b0;
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    // ignored transactions leave no expectation; give them time to fall out
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(4096));
    endcase
  endfunction

  function automatic logic [DRV_W-1:0] pick_level();
    case ($urandom_range(5))
      0: return '0;
      1: return DRV_TOP;
      default: return DRV_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [DRV_W-1:0]  hi, lo, base;
    logic [AXIS_W-1:0] axis;
    logic [POS_W-1:0]  target, measured;
    int                n;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero error, full-scale errors, ignored axis
    send_sample(2'd0, 16'h0000, 16'h0000);
    send_sample(2'd1, POS_MAX, POS_MIN);
    send_sample(2'd2, POS_MIN, POS_MAX);
    send_sample(2'd3, 16'($urandom), 16'($urandom));
    send_sample(2'd0, 16'h0064, 16'h0000);
    send_sample(2'd0, 16'h0000, 16'h0064);
    send_sample(2'd1, POS_MAX, POS_MAX);
    send_sample(2'd2, POS_MIN, POS_MIN);
    send_sample(2'd1, 16'h0010, 16'h0000);
    send_sample(2'd2, 16'hFFF0, 16'h0000);
    send_sample(2'd3, 16'hFFFF, 16'hFFFF);
    drain_pipeline();

    // crossed limits: out_min wins
    program_regs(KP_RESET, KI_RESET, KD_RESET, 12'd1000, 12'd3000, 12'd2000, 8'h00);
    send_sample(2'd0, 16'h0000, 16'h0000);
    send_sample(2'd1, 16'h1000, 16'h0000);
    send_sample(2'd2, 16'hF000, 16'h0000);
    drain_pipeline();

    program_regs('1, '1, '1, DRV_TOP, '0, '0, 8'hFF);
    send_sample(2'd0, POS_MAX, POS_MIN);
    send_sample(2'd1, POS_MIN, POS_MAX);
    send_sample(2'd2, 16'h0001, 16'h0000);
    send_sample(2'd0, 16'h0000, 16'h0000);
    send_sample(2'd3, POS_MAX, POS_MIN);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 86;
      end else if (phase < 6) begin
        send_idle_pct = 86;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_pipeline();
      if (phase == 6) holds_wanted++;
      case (phase)
        0: program_regs('1, '1, '1, DRV_TOP, '0, DRV_W'($urandom), 8'($urandom));
        1: program_regs('0, '0, '0, DRV_TOP, '0, DRV_TOP, 8'($urandom));
        2: program_regs(pick_gain(), pick_gain(), pick_gain(), '0, DRV_TOP, pick_level(),
                        8'($urandom));
        default: begin
          if ($urandom_range(3) == 0) begin
            hi = pick_level();
            lo = pick_level();
            base = pick_level();
          end else begin
            lo = DRV_W'($urandom_range(2000));
            hi = DRV_W'($urandom_range(4095, 2100));
            base = DRV_W'($urandom_range(hi, lo));
          end
          program_regs(pick_gain(), pick_gain(), pick_gain(), hi, lo, base, 8'($urandom));
        end
      endcase
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        axis = ($urandom_range(15) == 0) ? 2'd3 : AXIS_W'($urandom_range(AXES - 1));
        target = POS_W'($urandom);
        case ($urandom_range(9))
          0: begin
            target = $urandom_range(1) ? POS_MAX : POS_MIN;
            measured = $urandom_range(1) ? POS_MAX : POS_MIN;
          end
          1, 2: measured = POS_W'($urandom);
          default: measured = target + POS_W'(int'($urandom_range(600)) - 300);
        endcase
        send_sample(axis, target, measured);
        if (axis < AXES) n++;
      end
    end

    // wind the integrators up and down with full-scale errors, gains off
    drain_pipeline();
    program_regs('0, '0, '0, DRV_TOP, '0, 12'd2000, 8'($urandom));
    for (int i = 0; i < FILL_ROUNDS; i++) begin
      send_sample(2'd0, POS_MAX, POS_MIN);
      send_sample(2'd1, POS_MIN, POS_MAX);
      target = POS_W'($urandom);
      send_sample(2'd2, target, target + POS_W'(int'($urandom_range(600)) - 300));
    end
    drain_pipeline();
    // unit integral gain exposes the held integrator values
    program_regs('0, GAIN_W'(1), '0, DRV_TOP, '0, 12'd2000, 8'h00);
    send_sample(2'd0, 16'h0000, 16'h0000);
    send_sample(2'd1, 16'h0000, 16'h0000);
    send_sample(2'd0, POS_MAX, POS_MIN);
    send_sample(2'd1, POS_MIN, POS_MAX);
    send_sample(2'd2, 16'h0000, 16'h0000);
    drain_pipeline();

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/mapid_pkg.sv
design/mapid_state_ram.sv
design/multi_axis_pid_controller.sv
bench/pid_drive_checker.sv
bench/multi_axis_pid_controller_test.sv
